// ----- rtl/core/swbm_pkg.sv -----
// Shared types and constants for the sliding window bitrate meter.
// No dependencies; imported by every module under rtl/core.
package swbm_pkg;

  // Default ring depth in packets
  localparam int unsigned DefDepth = 1024;

  // Reset value of the window register in milliseconds
  localparam logic [15:0] WindowReset = 16'd5000;

  // 1000 ms per second times 256 for Q8 output
  localparam int unsigned MsQ8 = 256000;

  // Interval accumulator width: stays below window + 2^32
  localparam int unsigned IntervalW = 33;

  // Largest output values
  localparam logic [31:0] KbpsMax = 32'hFFFF_FFFF;
  localparam logic [27:0] FpsMax  = 28'hFFF_FFFF;

  // Request codes
  localparam logic ActRecord = 1'b0;
  localparam logic ActQuery  = 1'b1;

  // Query sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_END,
    ST_DIVK,
    ST_WAITK,
    ST_DIVF,
    ST_WAITF
  } swbm_state_e;

endpackage

// ----- rtl/core/swbm_ring.sv -----
// Packet ring storage: timestamp and size memories, one write and one read port.
// Depends on swbm_pkg for the DefDepth default.
module swbm_ring import swbm_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [31:0]              wtime_i,
  input  logic [15:0]              wsize_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [31:0]              rtime_o,
  output logic [15:0]              rsize_o
);

  logic [31:0] time_mem [DEPTH];
  logic [15:0] size_mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i] <= wtime_i;
      size_mem[waddr_i] <= wsize_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rtime_o <= time_mem[raddr_i];
    rsize_o <= size_mem[raddr_i];
  end

endmodule

// ----- rtl/core/swbm_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on swbm_pkg for the IntervalW default.
module swbm_div import swbm_pkg::*; #(
  parameter int unsigned NW = 29,
  parameter int unsigned DW = IntervalW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [NW-1:0] acc_q, acc_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;

  // One trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, acc_q[NW-1]};
    diff   = trial - {1'b0, den_q};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      den_d  = den_i;
      acc_d  = num_i;
    end else if (busy_q) begin
      rem_d = qbit ? diff[DW-1:0] : trial[DW-1:0];
      acc_d = {acc_q[NW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ----- rtl/core/sliding_window_bitrate_meter.sv -----
// Sliding window bitrate and frame rate meter, top level.
// Depends on swbm_pkg, swbm_ring and swbm_div.
//
// Usage:
//  - A request is taken when start is high and busy is low. action_i selects
//    a record (store timestamp_ms_i and packet_size_i in the ring) or a query.
//  - A record gives no result; busy stays low.
//  - A query walks back from the newest packet, one ring entry per cycle,
//    while the older entry is filled, the summed gap is below the window and
//    fewer than DEPTH-1 steps were taken. If the summed gap is nonzero, it
//    then runs two divisions on the shared serial divider.
//  - busy is high for the whole query and drops in the strobe cycle.
//  - The result is shown for one cycle with result_strobe_o; the receiver
//    cannot stall it.
//  - Configuration: window_ms written through cfg_valid_i / cfg_data_i;
//    cfg_ready_o is always high. Write only while idle.
//  - Reset clears the ring fill count, write pointer and sets window_ms to
//    5000. No clearing pass is needed: occupancy is tracked by a fill count.
module sliding_window_bitrate_meter import swbm_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] timestamp_ms_i,
  input  logic [15:0] packet_size_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        result_strobe_o,
  output logic [31:0] bitrate_kbps_o,
  output logic [27:0] frame_rate_q8_o,
  output logic        has_measurement_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned BW = 16 + PW;
  localparam int unsigned NW = BW + 3;
  localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);
  localparam logic [FW-1:0] FullCnt = FW'(DEPTH);

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  swbm_state_e state_q, state_d;

  logic [15:0]          window_q;
  logic [PW-1:0]        wptr_q, wptr_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [PW-1:0]        prev_q, prev_d;
  logic [PW-1:0]        steps_q, steps_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [BW-1:0]        bytes_q, bytes_d;
  logic [31:0]          cur_time_q, cur_time_d;
  logic [15:0]          cur_size_q, cur_size_d;
  logic [NW-1:0]        fnum_q;
  logic [31:0]          kbps_q;
  logic                 strobe_q, strobe_d;
  logic [31:0]          res_kbps_q;
  logic [27:0]          res_fps_q;
  logic                 res_has_q;

  logic                 accept;
  logic                 rec_we;
  logic [PW-1:0]        rd_addr;
  logic [31:0]          rd_time;
  logic [15:0]          rd_size;
  logic                 go;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic                 div_done;
  logic [NW-1:0]        div_quot;
  logic [NW+31:0]       quot_ext;
  logic [31:0]          kbps_sat;
  logic [27:0]          fps_sat;
  logic                 load_kbps;
  logic                 load_res;
  logic                 load_zero;

  assign accept      = start && !busy;
  assign rec_we      = accept && (action_i == ActRecord);
  assign cfg_ready_o = 1'b1;

  // Ring memories
  swbm_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (wptr_q),
    .wtime_i (timestamp_ms_i),
    .wsize_i (packet_size_i),
    .raddr_i (rd_addr),
    .rtime_o (rd_time),
    .rsize_o (rd_size)
  );

  // Shared divider for both rates
  swbm_div #(
    .NW (NW),
    .DW (IntervalW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (interval_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign div_num = (state_q == ST_DIVK) ? {bytes_q, 3'b000} : fnum_q;

  // Saturate quotient to the output widths
  always_comb begin
    quot_ext = {32'b0, div_quot};
    kbps_sat = (|quot_ext[NW+31:32]) ? KbpsMax : quot_ext[31:0];
    fps_sat  = (|quot_ext[NW+31:28]) ? FpsMax : quot_ext[27:0];
  end

  // Sequencer and walk datapath
  always_comb begin
    state_d    = state_q;
    wptr_d     = wptr_q;
    fill_d     = fill_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    interval_d = interval_q;
    bytes_d    = bytes_q;
    cur_time_d = cur_time_q;
    cur_size_d = cur_size_q;
    strobe_d   = 1'b0;
    div_start  = 1'b0;
    load_kbps  = 1'b0;
    load_res   = 1'b0;
    load_zero  = 1'b0;
    go         = 1'b0;
    rd_addr    = prev_q;
    busy       = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = ring_prev(wptr_q);
        if (accept) begin
          if (action_i == ActRecord) begin
            wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
            if (fill_q != FullCnt) begin
              fill_d = fill_q + 1'b1;
            end
          end else begin
            prev_d     = ring_prev(ring_prev(wptr_q));
            steps_d    = '0;
            interval_d = '0;
            bytes_d    = '0;
            state_d    = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // Read data holds the newest packet
        cur_time_d = rd_time;
        cur_size_d = rd_size;
        go = (window_q != '0) && (FW'(prev_q) < fill_q) && (LastIdx != '0);
        rd_addr = prev_q;
        state_d = go ? ST_STEP : ST_END;
      end
      ST_STEP: begin
        // Read data holds the older packet
        interval_d = interval_q + {1'b0, cur_time_q - rd_time};
        bytes_d    = bytes_q + BW'(cur_size_q);
        steps_d    = steps_q + 1'b1;
        cur_time_d = rd_time;
        cur_size_d = rd_size;
        prev_d     = ring_prev(prev_q);
        go = (steps_d < LastIdx) && (FW'(prev_d) < fill_q)
             && (interval_d < IntervalW'(window_q));
        rd_addr = prev_d;
        state_d = go ? ST_STEP : ST_END;
      end
      ST_END: begin
        if (interval_q == '0) begin
          load_zero = 1'b1;
          strobe_d  = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_DIVK;
        end
      end
      ST_DIVK: begin
        div_start = 1'b1;
        state_d   = ST_WAITK;
      end
      ST_WAITK: begin
        if (div_done) begin
          load_kbps = 1'b1;
          state_d   = ST_DIVF;
        end
      end
      ST_DIVF: begin
        div_start = 1'b1;
        state_d   = ST_WAITF;
      end
      ST_WAITF: begin
        if (div_done) begin
          load_res = 1'b1;
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      window_q <= WindowReset;
      wptr_q   <= '0;
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wptr_q   <= wptr_d;
      fill_q   <= fill_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
    end
  end

  // Walk accumulators and numerators
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    steps_q    <= steps_d;
    interval_q <= interval_d;
    bytes_q    <= bytes_d;
    cur_time_q <= cur_time_d;
    cur_size_q <= cur_size_d;
    if (state_q == ST_DIVK) begin
      fnum_q <= NW'(NW'(steps_q) * NW'(MsQ8));
    end
    if (load_kbps) begin
      kbps_q <= kbps_sat;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (load_zero) begin
      res_kbps_q <= '0;
      res_fps_q  <= '0;
      res_has_q  <= 1'b0;
    end else if (load_res) begin
      res_kbps_q <= kbps_q;
      res_fps_q  <= fps_sat;
      res_has_q  <= 1'b1;
    end
  end

  assign result_strobe_o   = strobe_q;
  assign bitrate_kbps_o    = res_kbps_q;
  assign frame_rate_q8_o   = res_fps_q;
  assign has_measurement_o = res_has_q;

endmodule

// ----- tb/tb_sliding_window_bitrate_meter.sv -----
// Self-checking testbench for sliding_window_bitrate_meter: directed and random
// record/query requests, with results predicted from a local copy of the packet ring.
// Depends on swbm_pkg and the RTL under rtl/core.
module tb_sliding_window_bitrate_meter;
  import swbm_pkg::*;

  localparam int unsigned RingDepth = DefDepth;

  typedef struct {
    logic        action;
    logic [31:0] stamp;
    logic [15:0] nbytes;
  } pkt_req_t;

  typedef struct {
    logic [31:0] kbps;
    logic [27:0] fps_q8;
    logic        valid_meas;
  } rate_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = ActRecord;
  logic [31:0] timestamp_ms_i = '0;
  logic [15:0] packet_size_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        result_strobe_o;
  logic [31:0] bitrate_kbps_o;
  logic [27:0] frame_rate_q8_o;
  logic        has_measurement_o;

  sliding_window_bitrate_meter #(
    .DEPTH(RingDepth)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .timestamp_ms_i   (timestamp_ms_i),
    .packet_size_i    (packet_size_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .result_strobe_o  (result_strobe_o),
    .bitrate_kbps_o   (bitrate_kbps_o),
    .frame_rate_q8_o  (frame_rate_q8_o),
    .has_measurement_o(has_measurement_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the packet ring and the window register
  logic [31:0] ring_stamp [RingDepth];
  logic [15:0] ring_bytes [RingDepth];
  bit          ring_filled [RingDepth];
  int unsigned wr_ptr = 0;
  logic [15:0] window_ms_q = WindowReset;

  pkt_req_t    pending_reqs [$];
  rate_t       rate_expect_q [$];
  int unsigned mismatch_count = 0;

  // Stimulus shaping, set per phase
  int unsigned idle_pct = 0;
  bit          no_idle = 1'b0;
  logic [31:0] next_stamp = '0;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic log_packet(input pkt_req_t req);
    ring_stamp[wr_ptr]  = req.stamp;
    ring_bytes[wr_ptr]  = req.nbytes;
    ring_filled[wr_ptr] = 1'b1;
    wr_ptr = (wr_ptr + 1) % RingDepth;
  endtask

  // Walk back from the newest packet and derive both rates
  function automatic rate_t measure_rate();
    int unsigned     newer;
    int unsigned     older;
    int unsigned     steps;
    logic [31:0]     gap;
    longint unsigned span;
    longint unsigned bytes;
    longint unsigned frames;
    longint unsigned kbps;
    longint unsigned fps;
    rate_t           r;
    newer  = (wr_ptr + RingDepth - 1) % RingDepth;
    older  = (newer + RingDepth - 1) % RingDepth;
    steps  = 0;
    span   = 0;
    bytes  = 0;
    frames = 0;
    kbps   = 0;
    fps    = 0;
    while (steps < RingDepth - 1 && ring_filled[older] && span < window_ms_q) begin
      gap    = ring_stamp[newer] - ring_stamp[older];  // modulo 2^32
      span   = span + gap;
      bytes  = bytes + ring_bytes[newer];
      frames = frames + 1;
      newer  = older;
      older  = (older + RingDepth - 1) % RingDepth;
      steps++;
    end
    if (span != 0) begin
      kbps = (64'd8 * bytes) / span;
      fps  = (64'(MsQ8) * frames) / span;
      if (kbps > 64'(KbpsMax)) kbps = 64'(KbpsMax);
      if (fps > 64'(FpsMax)) fps = 64'(FpsMax);
    end
    r.kbps       = kbps[31:0];
    r.fps_q8     = fps[27:0];
    r.valid_meas = (span != 0);
    return r;
  endfunction

  // Driver: presents queued requests, holds them while busy, idles in bursts
  pkt_req_t    cur_req;
  int unsigned idle_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        if (cur_req.action == ActQuery) rate_expect_q = {rate_expect_q, measure_rate()};
        else log_packet(cur_req);
      end
      if (!start || !busy) begin
        if (idle_left != 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() != 0 && !no_idle &&
                     $urandom_range(0, 99) < idle_pct) begin
          idle_left = $urandom_range(0, 8);
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          action_i       <= cur_req.action;
          timestamp_ms_i <= cur_req.stamp;
          packet_size_i  <= cur_req.nbytes;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is checked against the oldest pending query
  always @(posedge clk_i) begin
    rate_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (rate_expect_q.size() == 0) begin
        flag_mismatch("result strobe with no query outstanding");
      end else begin
        want = rate_expect_q.pop_front();
        if (bitrate_kbps_o !== want.kbps)
          flag_mismatch($sformatf("bitrate_kbps got %0d want %0d", bitrate_kbps_o, want.kbps));
        if (frame_rate_q8_o !== want.fps_q8)
          flag_mismatch($sformatf("frame_rate_q8 got %0d want %0d",
                                  frame_rate_q8_o, want.fps_q8));
        if (has_measurement_o !== want.valid_meas)
          flag_mismatch($sformatf("has_measurement got %0b want %0b",
                                  has_measurement_o, want.valid_meas));
      end
    end
  end

  task automatic push_record(input logic [31:0] stamp, input logic [15:0] nbytes);
    pkt_req_t req;
    req.action = ActRecord;
    req.stamp  = stamp;
    req.nbytes = nbytes;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic push_query();
    pkt_req_t req;
    req.action = ActQuery;
    req.stamp  = $urandom();
    req.nbytes = $urandom_range(0, 65535);
    pending_reqs = {pending_reqs, req};
  endtask

  // Hold off until every request is taken and every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || start || busy || rate_expect_q.size() != 0)
      @(negedge clk_i);
    // a record may still be finishing inside the block
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_ms_q = value;
  endtask

  // One random phase: mostly records with small gaps, some queries,
  // optional 32-bit jumps that also run timestamps backwards
  task automatic run_phase(input logic [15:0] window, input int unsigned count,
                           input int unsigned max_gap, input bit big_jumps,
                           input int unsigned query_pct, input int unsigned idle_p);
    int unsigned roll;
    logic [31:0] gap;
    logic [15:0] nbytes;
    wait_drained();
    write_window(window);
    @(negedge clk_i);
    idle_pct = idle_p;
    no_idle  = (idle_p == 0);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        push_query();
      end else begin
        roll = $urandom_range(0, 99);
        if (big_jumps && roll < 3) gap = $urandom();
        else if (roll < 15) gap = '0;
        else gap = $urandom_range(0, max_gap);
        next_stamp = next_stamp + gap;
        roll = $urandom_range(0, 19);
        if (roll == 0) nbytes = '0;
        else if (roll == 1) nbytes = '1;
        else nbytes = $urandom_range(0, 65535);
        push_record(next_stamp, nbytes);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_pct = 25;

    // Directed part at the reset window
    push_query();                          // empty ring
    push_record(32'hFFFF_FFFF, 16'hFFFF);
    push_query();                          // single packet
    push_record(32'hFFFF_FFFF, 16'h0000);
    push_query();                          // zero interval
    push_record(32'h0000_0009, 16'hFFFF);
    push_query();                          // gap across the 2^32 wrap
    push_record(32'h0000_0000, 16'h0001);
    push_query();                          // backwards stamp, huge gap
    push_record(32'd1388, 16'd1500);
    push_record(32'd6388, 16'd1500);
    push_query();                          // gap equal to the window
    next_stamp = 32'd6388;

    // Window of zero takes no step
    wait_drained();
    write_window(16'h0000);
    @(negedge clk_i);
    push_query();

    // Widest window; the walk still stops at the huge backwards gap
    wait_drained();
    write_window(16'hFFFF);
    @(negedge clk_i);
    push_query();

    // Random phases; later ones keep gaps small so the walk reaches the cap
    run_phase(16'd1, 150, 20, 1'b1, 20, 30);
    run_phase(16'($urandom_range(2, 65534)), 150, 200, 1'b1, 20, 0);
    run_phase(16'd300, 250, 40, 1'b0, 15, 20);
    run_phase(16'($urandom_range(1, 4000)), 250, 40, 1'b0, 15, 40);
    run_phase(16'hFFFF, 800, 3, 1'b0, 10, 0);

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && rate_expect_q.size() == 0) begin
      $display("sliding_window_bitrate_meter test passed");
    end else begin
      $display("sliding_window_bitrate_meter test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #60_000_000;
    $display("sliding_window_bitrate_meter test failed");
    $finish;
  end

endmodule
